// ===== hdl/chse_pkg.sv =====
// ----------------------------------------------------------------------------
// chse_pkg: shared types and constants for the Chebyshev series evaluator
// Request and result payloads, number formats and small helpers used by the
// sequencer and the datapath modules.
// ----------------------------------------------------------------------------
package chse_pkg;

  // Default table depth and fixed field widths.
  localparam int COEF_COUNT = 16;
  localparam int DEG_W      = 4;
  localparam int IDX_W      = 4;
  localparam int COEF_W     = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 64;

  // One in Q1.30, at operand width and at the width of a recurrence difference.
  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
  localparam logic signed [33:0] ONE_Q30W = 34'sd1073741824;

  // Request operation codes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  // Request payload.
  typedef struct packed {
    op_t                operation;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] x_value;
  } cmd_t;

  // Result payload.
  typedef struct packed {
    logic signed [47:0] series_value;
    logic               overflow;
  } result_t;

  // Operands presented to the shared multiplier.
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  // Clamp a value to the closed range [-1, +1] in Q1.30.
  function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30W) begin
      r = ONE_Q30;
    end else if (v < -ONE_Q30W) begin
      r = -ONE_Q30;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/chse_coef_mem.sv =====
// ----------------------------------------------------------------------------
// chse_coef_mem: coefficient table
// Single write port and one registered read port. Entries hold no reset value;
// a slot must only be read after it has been written; the block does not enforce this.
// ----------------------------------------------------------------------------
module chse_coef_mem #(
  parameter int DEPTH = chse_pkg::COEF_COUNT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [31:0]       wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [31:0]       rdata
);

  logic signed [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, sampled every cycle.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/chse_mul.sv =====
// ----------------------------------------------------------------------------
// chse_mul: shared signed multiplier
// One 32 x 32 signed multiply per cycle with the full product registered.
// Used both for the recurrence product and for each coefficient term.
// ----------------------------------------------------------------------------
module chse_mul (
  input  logic                                clk,
  input  chse_pkg::mul_req_t                  req,
  output logic signed [chse_pkg::PROD_W-1:0]  prod
);

  // Full-width product, registered.
  always_ff @(posedge clk) begin
    prod <= chse_pkg::PROD_W'(req.a) * chse_pkg::PROD_W'(req.b);
  end

endmodule

// ===== hdl/chebyshev_series_eval.sv =====
// ----------------------------------------------------------------------------
// chebyshev_series_eval: fixed-point Chebyshev series evaluator
// Sums c[i]*T_i(x) for i = 0..degree using T_i = 2x*T_{i-1} - T_{i-2}, with a
// coefficient table filled by write requests and one shared multiplier.
//
//   Channel   Signals                          Direction  Handshake
//   request   start, busy, cmd                 in         start && !busy
//   result    result_valid, result             out        one-cycle strobe
//   config    degree_we, degree_wdata          in         write on degree_we
//
// A write request leaves busy low. An evaluate request keeps busy high while
// the sequencer runs FETCH and INIT, which end it when n (degree limited to
// COEF_COUNT-1) is zero; otherwise TERM, REC and STEP follow for each term
// but the last, then TERM and LAST. The result strobe follows in the next
// cycle. The term and recurrence products share one multiplier; STEP clamps T_i.
// Reset returns the sequencer to idle and sets degree to zero; the table is
// left as it is. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module chebyshev_series_eval #(
  parameter int COEF_COUNT = chse_pkg::COEF_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  chse_pkg::cmd_t                cmd,
  output logic                          result_valid,
  output chse_pkg::result_t             result,
  input  logic                          degree_we,
  input  logic [chse_pkg::DEG_W-1:0]    degree_wdata
);

  localparam int AW    = $clog2(COEF_COUNT);
  localparam int DEG_W = chse_pkg::DEG_W;
  localparam int ACC_W = chse_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_INIT,
    S_TERM,
    S_REC,
    S_STEP,
    S_LAST
  } state_t;

  state_t                       state;
  logic [DEG_W-1:0]             degree;
  logic [DEG_W-1:0]             n_last;
  logic [DEG_W-1:0]             idx;
  logic signed [31:0]           xr;
  logic signed [31:0]           tprev;
  logic signed [31:0]           tcur;
  logic signed [ACC_W-1:0]      acc;
  logic                         flag;

  logic                         accept;
  logic                         mem_we;
  logic signed [31:0]           rdata;
  chse_pkg::mul_req_t           mul_req;
  logic signed [chse_pkg::PROD_W-1:0] prod;
  logic [DEG_W-1:0]             n_start;
  logic signed [33:0]           term;
  logic signed [ACC_W:0]        sum;
  logic signed [ACC_W-1:0]      sum_sat;
  logic                         sum_ovf;
  logic signed [33:0]           rec_diff;
  logic signed [ACC_W-1:0]      acc_max;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Table writes; slots beyond the table are dropped.
  assign mem_we = accept && (cmd.operation == chse_pkg::OP_WRITE) &&
                  (32'(cmd.coef_index) < COEF_COUNT);

  chse_coef_mem #(
    .DEPTH (COEF_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(cmd.coef_index)),
    .wdata (cmd.coef_value),
    .raddr (AW'(idx)),
    .rdata (rdata)
  );

  // The multiplier takes x for the recurrence and the coefficient otherwise.
  always_comb begin
    mul_req.a = (state == S_REC) ? xr : rdata;
    mul_req.b = tcur;
  end

  chse_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // Degree limited to the last table slot.
  assign n_start = (32'(degree) > COEF_COUNT - 1) ? DEG_W'(COEF_COUNT - 1) : degree;

  // Term in Q.24: product floor-shifted by 30, then saturating accumulation.
  assign acc_max = {1'b0, {(ACC_W-1){1'b1}}};
  assign term    = prod[63:30];
  assign sum     = {acc[ACC_W-1], acc} + (ACC_W+1)'(term);
  assign sum_ovf = (sum[ACC_W] != sum[ACC_W-1]);
  assign sum_sat = sum_ovf ? (sum[ACC_W] ? ~acc_max : acc_max) : sum[ACC_W-1:0];

  // Next Chebyshev value before clamping: 2x*T_{i-1} - T_{i-2}.
  assign rec_diff = prod[62:29] - 34'(tprev);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
    end else if (degree_we) begin
      degree <= degree_wdata;
    end
  end

  // Sequencer with its working registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd.operation == chse_pkg::OP_EVAL)) begin
            xr     <= chse_pkg::clamp_one(34'(cmd.x_value));
            n_last <= n_start;
            idx    <= '0;
            state  <= S_FETCH;
          end
        end
        S_FETCH: begin
          idx   <= DEG_W'(1);
          state <= S_INIT;
        end
        S_INIT: begin
          acc   <= ACC_W'(rdata);
          flag  <= 1'b0;
          tprev <= chse_pkg::ONE_Q30;
          tcur  <= xr;
          if (n_last == '0) begin
            result.series_value <= ACC_W'(rdata);
            result.overflow     <= 1'b0;
            result_valid        <= 1'b1;
            state               <= S_IDLE;
          end else begin
            state <= S_TERM;
          end
        end
        S_TERM: begin
          if (idx == n_last) begin
            state <= S_LAST;
          end else begin
            state <= S_REC;
          end
        end
        S_REC: begin
          acc   <= sum_sat;
          flag  <= flag | sum_ovf;
          idx   <= idx + DEG_W'(1);
          state <= S_STEP;
        end
        S_STEP: begin
          tprev <= tcur;
          tcur  <= chse_pkg::clamp_one(rec_diff);
          state <= S_TERM;
        end
        S_LAST: begin
          result.series_value <= sum_sat;
          result.overflow     <= flag | sum_ovf;
          result_valid        <= 1'b1;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the Chebyshev series evaluator
// Fills the coefficient table, then sends write and evaluate requests with
// random gaps while the degree register is stepped between phases. Each
// result strobe is checked against a bit-accurate fixed-point prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Unit value in Q1.30 and the limits of the Q24.24 accumulator.
  localparam longint UNIT_Q30    = longint'(chse_pkg::ONE_Q30);
  localparam longint SUM_MAX     = (longint'(1) <<< 47) - 1;
  localparam longint SUM_MIN     = -(longint'(1) <<< 47);
  // Cycles allowed to pass once nothing is outstanding, and the stall limit.
  localparam int     IDLE_SETTLE = 4;
  localparam int     END_SETTLE  = 60;
  localparam int     STALL_LIMIT = 5000;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  chse_pkg::cmd_t                 cmd;
  logic                           result_valid;
  chse_pkg::result_t              result;
  logic                           degree_we;
  logic [chse_pkg::DEG_W-1:0]     degree_wdata;

  // Shadow copy of the block's state, kept in request order.
  logic signed [31:0]             coef_shadow [chse_pkg::COEF_COUNT];
  logic [chse_pkg::DEG_W-1:0]     degree_shadow;
  chse_pkg::result_t              expected_sums [$];

  int                             error_count = 0;
  int                             stall_cycles = 0;
  bit                             gaps_on;

  chebyshev_series_eval i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .degree_we    (degree_we),
    .degree_wdata (degree_wdata)
  );

  // Clock generation.
  always #4 clk = ~clk;

  // Clamp a Q1.30 value to [-1, +1].
  function automatic longint clamp_unit(input longint v);
    if (v > UNIT_Q30) begin
      return UNIT_Q30;
    end
    if (v < -UNIT_Q30) begin
      return -UNIT_Q30;
    end
    return v;
  endfunction

  // Accumulate with saturation, raising the flag on a clipped step.
  function automatic longint sat_add(input longint a, input longint b, inout bit flag);
    longint s;
    s = a + b;
    if (s > SUM_MAX) begin
      flag = 1'b1;
      return SUM_MAX;
    end
    if (s < SUM_MIN) begin
      flag = 1'b1;
      return SUM_MIN;
    end
    return s;
  endfunction

  // Series sum at x for the current table and degree.
  function automatic chse_pkg::result_t chebyshev_sum(input logic signed [31:0] x_raw);
    chse_pkg::result_t r;
    longint  x;
    longint  t_prev;
    longint  t_cur;
    longint  t_next;
    longint  acc;
    int      n;
    int      i;
    bit      sat;
    sat = 1'b0;
    n   = int'(degree_shadow);
    if (n > chse_pkg::COEF_COUNT - 1) begin
      n = chse_pkg::COEF_COUNT - 1;
    end
    x   = clamp_unit(longint'(x_raw));
    acc = sat_add(0, longint'(coef_shadow[0]), sat);
    if (n >= 1) begin
      acc    = sat_add(acc, (longint'(coef_shadow[1]) * x) >>> 30, sat);
      t_prev = UNIT_Q30;
      t_cur  = x;
      for (i = 2; i <= n; i++) begin
        t_next = clamp_unit(((x * t_cur) >>> 29) - t_prev);
        acc    = sat_add(acc, (longint'(coef_shadow[i]) * t_next) >>> 30, sat);
        t_prev = t_cur;
        t_cur  = t_next;
      end
    end
    r.series_value = acc[47:0];
    r.overflow     = sat;
    return r;
  endfunction

  // Gap before a request: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Present one request, wait for it to be taken and predict its effect.
  task automatic send_request(input chse_pkg::cmd_t c);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c.operation == chse_pkg::OP_WRITE) begin
      coef_shadow[c.coef_index] = c.coef_value;
    end else begin
      expected_sums.push_back(chebyshev_sum(c.x_value));
    end
  endtask

  // Drop start and wait until every result is in and the block is quiet.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_sums.size() != 0 || busy) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Write the degree register while the block is idle.
  task automatic set_degree(input logic [chse_pkg::DEG_W-1:0] d);
    wait_idle();
    @(negedge clk);
    degree_we    <= 1'b1;
    degree_wdata <= d;
    @(posedge clk);
    degree_shadow = d;
    @(negedge clk);
    degree_we <= 1'b0;
  endtask

  task automatic write_coef(input logic [3:0] idx, input logic signed [31:0] v);
    chse_pkg::cmd_t c;
    c.operation  = chse_pkg::OP_WRITE;
    c.coef_index = idx;
    c.coef_value = v;
    c.x_value    = $urandom();
    send_request(c);
  endtask

  task automatic eval_at(input logic signed [31:0] x);
    chse_pkg::cmd_t c;
    c.operation  = chse_pkg::OP_EVAL;
    c.coef_index = 4'($urandom_range(0, 15));
    c.coef_value = $urandom();
    c.x_value    = x;
    send_request(c);
  endtask

  // Every slot is written before any evaluation reads it.
  task automatic test_table_fill();
    int i;
    for (i = 0; i < chse_pkg::COEF_COUNT; i++) begin
      case (i % 4)
        0: begin
          write_coef(4'(i), 32'sh7FFF_FFFF);
        end
        1: begin
          write_coef(4'(i), 32'sh8000_0000);
        end
        2: begin
          write_coef(4'(i), 32'sh0000_0000);
        end
        default: begin
          write_coef(4'(i), -32'sd1);
        end
      endcase
    end
  endtask

  // Arguments at, inside and beyond the clamp limits at the highest degree.
  task automatic test_argument_edges();
    set_degree(4'd15);
    eval_at(32'sh7FFF_FFFF);
    eval_at(32'sh8000_0000);
    eval_at(32'sh4000_0000);
    eval_at(-32'sh4000_0000);
    eval_at(32'sh4000_0001);
    eval_at(32'sh3FFF_FFFF);
    eval_at(-32'sh3FFF_FFFF);
    eval_at(32'sh0000_0000);
  endtask

  // The lowest degrees, where the recurrence is skipped.
  task automatic test_degree_limits();
    set_degree(4'd0);
    eval_at(32'sh1234_5678);
    set_degree(4'd1);
    eval_at(-32'sh2345_6789);
  endtask

  // Random phases: each sets a degree and sends a mix of writes and
  // evaluations, with gaps switched off for every third phase.
  task automatic test_random_series();
    int          phase;
    int          k;
    logic [31:0] v;
    logic [31:0] x;
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 0) begin
        set_degree(4'd0);
      end else if (phase == 1) begin
        set_degree(4'd15);
      end else begin
        set_degree(4'($urandom_range(0, 15)));
      end
      gaps_on = (phase % 3 != 2);
      for (k = 0; k < 100; k++) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
          end else begin
            v = $urandom();
          end
          write_coef(4'($urandom_range(0, 15)), v);
        end else begin
          case ($urandom_range(0, 3))
            0: begin
              x = $urandom();
            end
            1: begin
              // Close to plus or minus one, where the recurrence may drift.
              x = 32'h4000_0000 - $urandom_range(0, 64);
              if ($urandom_range(0, 1) == 1) begin
                x = -x;
              end
            end
            default: begin
              x = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            end
          endcase
          eval_at(x);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Check each result strobe against the oldest prediction.
  always @(posedge clk) begin
    chse_pkg::result_t want;
    if (!rst && result_valid) begin
      if (expected_sums.size() == 0) begin
        $error("result with no request outstanding: series_value %0d overflow %0b",
               result.series_value, result.overflow);
        error_count++;
      end else begin
        want = expected_sums.pop_front();
        if (result.series_value !== want.series_value) begin
          $error("series_value: expected %0d, got %0d",
                 want.series_value, result.series_value);
          error_count++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    degree_we     = 1'b0;
    degree_wdata  = '0;
    degree_shadow = '0;
    gaps_on       = 1'b1;
    for (int i = 0; i < chse_pkg::COEF_COUNT; i++) begin
      coef_shadow[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_argument_edges();
    test_degree_limits();
    test_random_series();

    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
